### hw/rtl/png_stored_image_encoder_defines.svh
// Assertion macros used by the checker file of the PNG encoder
`ifndef PNG_STORED_IMAGE_ENCODER_DEFINES_SVH
`define PNG_STORED_IMAGE_ENCODER_DEFINES_SVH

// Implication checked at every rising edge outside reset
`define PSE_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Implication checked in the cycle after its antecedent
`define PSE_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### hw/rtl/pse_pkg.sv
// Types, constants and helper functions of the PNG stored-image encoder
`timescale 1ns / 1ps
package pse_pkg;

  localparam int DIM_W       = 15;
  localparam int COL_W       = 14;
  localparam int BLK_W       = 16;
  localparam int STREAM_W    = 27;
  localparam int DIV_W       = 28;
  localparam int LEN_W       = 32;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int PROD_W      = 30;

  localparam int STORED_BLOCK_MAX_DEF = 65535;
  localparam int MAX_IMAGE_BYTES_DEF  = 67108864;

  localparam logic [DIM_W-1:0]  DIM_MAX   = 15'd16384;
  localparam logic [16:0]       ADLER_MOD = 17'd65521;
  localparam logic [31:0]       CRC_POLY  = 32'hedb88320;
  localparam logic [31:0]       IEND_CRC  = 32'hae426082;
  localparam logic [CNT_W-1:0]  OUT_CAP   = 6'd53;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 2'd2;

  // input actions
  localparam logic ACT_PIXEL  = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHK1, ST_CHK2, ST_DIV, ST_SIG, ST_IHL, ST_IHDR, ST_IHC,
    ST_IDL, ST_IDT, ST_DATA, ST_BHDR, ST_FIN, ST_ERR
  } state_t;

  typedef struct packed {
    logic       crc_init;
    logic       crc_feed;
    logic       adler_init;
    logic       adler_feed;
    logic [7:0] data;
  } sum_ctl_t;

  // one byte through the reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  // PNG signature bytes
  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'd137;
      3'd1: r = 8'd80;
      3'd2: r = 8'd78;
      3'd3: r = 8'd71;
      3'd4: r = 8'd13;
      3'd5: r = 8'd10;
      3'd6: r = 8'd26;
      default: r = 8'd10;
    endcase
    return r;
  endfunction

  // big-endian byte i of a 32-bit word
  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0: r = w[31:24];
      2'd1: r = w[23:16];
      2'd2: r = w[15:8];
      default: r = w[7:0];
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/pse_if.sv
// Handshake interfaces of the pixel input and byte output channels
`timescale 1ns / 1ps
interface pse_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] pixel_byte0;
  logic [7:0] pixel_byte1;
  logic [7:0] pixel_byte2;
  logic [7:0] pixel_byte3;
  modport source (output valid, action, pixel_byte0, pixel_byte1, pixel_byte2, pixel_byte3,
                  input ready);
  modport sink   (input valid, action, pixel_byte0, pixel_byte1, pixel_byte2, pixel_byte3,
                  output ready);
endinterface

interface pse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       failed;
  modport source (output valid, out_byte, run_last, failed, input ready);
  modport sink   (input valid, out_byte, run_last, failed, output ready);
endinterface

### hw/rtl/pse_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle
`timescale 1ns / 1ps
module pse_divider #(
  parameter int DIVIDEND_W = pse_pkg::DIV_W,
  parameter int DIVISOR_W  = pse_pkg::BLK_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);
  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt, done_r, done_nxt;
  logic [DIVISOR_W:0]    trial;

  // shift one dividend bit into the remainder and try the subtraction
  always_comb begin
    trial    = {rem_r, quo_r[DIVIDEND_W-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
        quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

### hw/rtl/pse_checksum.sv
// Running CRC-32 and Adler-32, updated one byte per cycle
`timescale 1ns / 1ps
module pse_checksum (
  input  logic               clk,
  input  logic               rst_n,
  input  pse_pkg::sum_ctl_t  ctl,
  output logic [31:0]        crc,
  output logic [15:0]        adler_low,
  output logic [15:0]        adler_high
);
  logic [31:0] crc_r, crc_nxt;
  logic [15:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [16:0] lo_sum, lo_mod, hi_sum;

  // fold one byte into both sums
  always_comb begin
    lo_sum  = {1'b0, lo_r} + {9'd0, ctl.data};
    lo_mod  = (lo_sum >= pse_pkg::ADLER_MOD) ? lo_sum - pse_pkg::ADLER_MOD : lo_sum;
    hi_sum  = {1'b0, hi_r} + lo_mod;
    crc_nxt = crc_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (ctl.crc_init) crc_nxt = '1;
    else if (ctl.crc_feed) crc_nxt = pse_pkg::crc_byte(crc_r, ctl.data);
    if (ctl.adler_init) begin
      lo_nxt = 16'd1;
      hi_nxt = 16'd0;
    end else if (ctl.adler_feed) begin
      lo_nxt = lo_mod[15:0];
      hi_nxt = (hi_sum >= pse_pkg::ADLER_MOD) ? 16'(hi_sum - pse_pkg::ADLER_MOD)
                                              : hi_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '1;
      lo_r  <= 16'd1;
      hi_r  <= 16'd0;
    end else begin
      crc_r <= crc_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
    end
  end

  assign crc        = crc_r;
  assign adler_low  = lo_r;
  assign adler_high = hi_r;
endmodule

### hw/rtl/png_stored_image_encoder.sv
// Top level of the PNG stored-image encoder: byte sequencer and output register
//
// Use: write image_width, image_height and channel_order on the cfg port while no
// image is open, then send width*height pixel words (action 0) in raster order and
// one finish word (action 1). Each input word yields a run of bytes on the output
// channel; run_last marks the final byte of the run, failed marks an error byte.
// Before its first byte the first pixel is taken, passes a size check and waits for
// a bit-serial division (one quotient bit per cycle) for the IDAT length; then
// come 43 header bytes. After that a pixel is taken and yields its output bytes:
// four pixel bytes, a filter byte at each row start and five bytes per stored
// block header. A finish word gives 20 bytes.
// The output byte path, one byte per cycle while out_ch.ready is high, sets the rate.
// Only one input word is worked on at a time; in_ch.ready is high while idle.
// A stalled receiver holds the output register and the sequencer waits with it.
// Synchronous reset closes any image and restores the register defaults.
// No output byte is lost while out_ch.ready is low.
`timescale 1ns / 1ps
module png_stored_image_encoder #(
  parameter int STORED_BLOCK_MAX = pse_pkg::STORED_BLOCK_MAX_DEF,
  parameter int MAX_IMAGE_BYTES  = pse_pkg::MAX_IMAGE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pse_pkg::DIM_W-1:0]      cfg_data,
  pse_in_if.sink                         in_ch,
  pse_out_if.source                      out_ch
);
  localparam logic [pse_pkg::BLK_W-1:0]    BLK_MAX = pse_pkg::BLK_W'(STORED_BLOCK_MAX);
  localparam logic [31:0]                  IMG_MAX = 32'(MAX_IMAGE_BYTES);
  localparam logic [pse_pkg::DIV_W-1:0]    BLK_RND = pse_pkg::DIV_W'(STORED_BLOCK_MAX - 1);

  pse_pkg::state_t state_r, state_nxt;

  logic [pse_pkg::DIM_W-1:0]    width_r, height_r;
  logic                         order_r;
  logic                         open_r, open_nxt;
  logic [pse_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [pse_pkg::DIM_W-1:0]    row_r, row_nxt;
  logic [pse_pkg::BLK_W-1:0]    blk_r, blk_nxt, n_r, n_nxt;
  logic [pse_pkg::STREAM_W-1:0] stream_r, stream_nxt, s_r, s_nxt;
  logic [pse_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic [pse_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [pse_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [pse_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [7:0]                   px_r [4];
  logic [7:0]                   px_nxt [4];

  logic       ov_r, ol_r, of_r;
  logic [7:0] ob_r;

  logic       emit, true_last, err_byte, visible, load, adv;
  logic [7:0] byte_v;
  logic       accept, bad;
  logic [pse_pkg::BLK_W-1:0] n_v;
  logic [pse_pkg::STREAM_W-1:0] cap_v;
  logic [pse_pkg::DIV_W-1:0]    quo;
  logic                         div_done, div_start;
  logic [31:0]                  crc;
  logic [15:0]                  a_lo, a_hi;
  pse_pkg::sum_ctl_t            sum;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == pse_pkg::ST_IDLE);

  // hold configuration; writes are dropped while an image is open
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 15'd1;
      height_r <= 15'd1;
      order_r  <= 1'b0;
    end else if (cfg_we && !open_r) begin
      unique case (cfg_index)
        pse_pkg::REG_WIDTH:  width_r  <= cfg_data;
        pse_pkg::REG_HEIGHT: height_r <= cfg_data;
        pse_pkg::REG_ORDER:  order_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pse_divider #(.DIVIDEND_W(pse_pkg::DIV_W), .DIVISOR_W(pse_pkg::BLK_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({1'b0, s_r} + BLK_RND),
    .divisor  (BLK_MAX),
    .done     (div_done),
    .quotient (quo)
  );

  pse_checksum u_sum (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (sum),
    .crc        (crc),
    .adler_low  (a_lo),
    .adler_high (a_hi)
  );

  assign cap_v = pse_pkg::STREAM_W'(BLK_MAX);
  assign n_v   = (stream_r < cap_v) ? stream_r[pse_pkg::BLK_W-1:0] : BLK_MAX;
  assign bad   = (width_r == '0) || (height_r == '0) || (width_r > pse_pkg::DIM_MAX) ||
                 (height_r > pse_pkg::DIM_MAX) || ({prod_r, 2'b00} > IMG_MAX);
  assign visible = (cnt_r < pse_pkg::OUT_CAP);
  assign load    = !ov_r || out_ch.ready;
  assign adv     = emit && (load || !visible);
  assign div_start = (state_r == pse_pkg::ST_DIV) && (idx_r == '0);

  // sequence the byte stream
  always_comb begin
    state_nxt  = state_r;
    open_nxt   = open_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    blk_nxt    = blk_r;
    n_nxt      = n_r;
    stream_nxt = stream_r;
    s_nxt      = s_r;
    prod_nxt   = prod_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    px_nxt     = px_r;
    emit       = 1'b0;
    true_last  = 1'b0;
    err_byte   = 1'b0;
    byte_v     = 8'd0;
    sum        = '0;
    unique case (state_r)
      pse_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          px_nxt[0] = order_r ? in_ch.pixel_byte2 : in_ch.pixel_byte0;
          px_nxt[1] = in_ch.pixel_byte1;
          px_nxt[2] = order_r ? in_ch.pixel_byte0 : in_ch.pixel_byte2;
          px_nxt[3] = in_ch.pixel_byte3;
          if (in_ch.action == pse_pkg::ACT_PIXEL) begin
            if (!open_r) begin
              state_nxt = pse_pkg::ST_CHK1;
            end else if (row_r >= height_r) begin
              state_nxt = pse_pkg::ST_ERR;
            end else begin
              state_nxt = pse_pkg::ST_DATA;
              idx_nxt   = (col_r == '0) ? 5'd0 : 5'd1;
            end
          end else begin
            if (!open_r || row_r != height_r || col_r != '0) state_nxt = pse_pkg::ST_ERR;
            else begin
              state_nxt = pse_pkg::ST_FIN;
              idx_nxt   = '0;
            end
          end
        end
      end
      pse_pkg::ST_CHK1: begin
        prod_nxt  = width_r * height_r;
        state_nxt = pse_pkg::ST_CHK2;
      end
      pse_pkg::ST_CHK2: begin
        if (bad) state_nxt = pse_pkg::ST_ERR;
        else begin
          s_nxt     = {12'd0, height_r} * {10'd0, width_r, 2'b01};
          idx_nxt   = '0;
          state_nxt = pse_pkg::ST_DIV;
        end
      end
      pse_pkg::ST_DIV: begin
        idx_nxt = 5'd1;
        if (div_done) begin
          len_nxt = 32'd6 + {quo, 2'b00} + {4'd0, quo} + {5'd0, s_r};
          // open the image
          open_nxt       = 1'b1;
          col_nxt        = '0;
          row_nxt        = '0;
          blk_nxt        = '0;
          stream_nxt     = s_r;
          sum.crc_init   = 1'b1;
          sum.adler_init = 1'b1;
          idx_nxt        = '0;
          state_nxt      = pse_pkg::ST_SIG;
        end
      end
      pse_pkg::ST_SIG: begin
        emit   = 1'b1;
        byte_v = pse_pkg::sig_byte(idx_r[2:0]);
        if (adv) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 5'd7) begin
            idx_nxt   = '0;
            state_nxt = pse_pkg::ST_IHL;
          end
        end
      end
      pse_pkg::ST_IHL: begin
        emit   = 1'b1;
        byte_v = pse_pkg::be_byte(32'd13, idx_r[1:0]);
        if (adv) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 5'd3) begin
            idx_nxt   = '0;
            state_nxt = pse_pkg::ST_IHDR;
          end
        end
      end
      pse_pkg::ST_IHDR: begin
        emit = 1'b1;
        priority if (idx_r == 5'd0) byte_v = "I";
        else if (idx_r == 5'd1) byte_v = "H";
        else if (idx_r == 5'd2) byte_v = "D";
        else if (idx_r == 5'd3) byte_v = "R";
        else if (idx_r < 5'd8) byte_v = pse_pkg::be_byte({17'd0, width_r}, 2'(idx_r - 5'd4));
        else if (idx_r < 5'd12) byte_v = pse_pkg::be_byte({17'd0, height_r}, 2'(idx_r - 5'd8));
        else if (idx_r == 5'd12) byte_v = 8'd8;
        else if (idx_r == 5'd13) byte_v = 8'd6;
        else byte_v = 8'd0;
        sum.crc_feed = adv;
        if (adv) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 5'd16) begin
            idx_nxt   = '0;
            state_nxt = pse_pkg::ST_IHC;
          end
        end
      end
      pse_pkg::ST_IHC: begin
        emit   = 1'b1;
        byte_v = pse_pkg::be_byte(~crc, idx_r[1:0]);
        if (adv) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 5'd3) begin
            sum.crc_init = 1'b1;
            idx_nxt      = '0;
            state_nxt    = pse_pkg::ST_IDL;
          end
        end
      end
      pse_pkg::ST_IDL: begin
        emit   = 1'b1;
        byte_v = pse_pkg::be_byte(len_r, idx_r[1:0]);
        if (adv) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 5'd3) begin
            idx_nxt   = '0;
            state_nxt = pse_pkg::ST_IDT;
          end
        end
      end
      pse_pkg::ST_IDT: begin
        emit = 1'b1;
        priority if (idx_r == 5'd0) byte_v = "I";
        else if (idx_r == 5'd1) byte_v = "D";
        else if (idx_r == 5'd2) byte_v = "A";
        else if (idx_r == 5'd3) byte_v = "T";
        else if (idx_r == 5'd4) byte_v = 8'h78;
        else byte_v = 8'h01;
        sum.crc_feed = adv;
        if (adv) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 5'd5) begin
            idx_nxt   = '0;
            state_nxt = pse_pkg::ST_DATA;
          end
        end
      end
      pse_pkg::ST_DATA: begin
        emit = 1'b1;
        if (blk_r == '0) begin
          // first byte of a stored block header: final-block flag
          byte_v       = {7'd0, stream_r <= cap_v};
          sum.crc_feed = adv;
          if (adv) begin
            n_nxt     = n_v;
            cnt_nxt   = cnt_r;
            state_nxt = pse_pkg::ST_BHDR;
          end
        end else begin
          byte_v         = (idx_r == '0) ? 8'd0 : px_r[2'(idx_r - 5'd1)];
          true_last      = (idx_r == 5'd4);
          sum.crc_feed   = adv;
          sum.adler_feed = adv;
          if (adv) begin
            blk_nxt    = blk_r - 1'b1;
            stream_nxt = (stream_r != '0) ? stream_r - 1'b1 : stream_r;
            idx_nxt    = idx_r + 1'b1;
            if (idx_r == 5'd4) begin
              state_nxt = pse_pkg::ST_IDLE;
              if ({1'b0, col_r} + 15'd1 >= width_r) begin
                col_nxt = '0;
                row_nxt = row_r + 1'b1;
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
          end
        end
      end
      pse_pkg::ST_BHDR: begin
        // length and its complement, low byte first; blk_r doubles as byte counter
        emit = 1'b1;
        priority if (blk_r == 16'd0) byte_v = n_r[7:0];
        else if (blk_r == 16'd1) byte_v = n_r[15:8];
        else if (blk_r == 16'd2) byte_v = ~n_r[7:0];
        else byte_v = ~n_r[15:8];
        sum.crc_feed = adv;
        if (adv) begin
          blk_nxt = blk_r + 1'b1;
          if (blk_r == 16'd3) begin
            blk_nxt   = n_r;
            state_nxt = pse_pkg::ST_DATA;
          end
        end
      end
      pse_pkg::ST_FIN: begin
        emit = 1'b1;
        priority if (idx_r < 5'd4) byte_v = pse_pkg::be_byte({a_hi, a_lo}, idx_r[1:0]);
        else if (idx_r < 5'd8) byte_v = pse_pkg::be_byte(~crc, idx_r[1:0]);
        else if (idx_r < 5'd12) byte_v = 8'd0;
        else if (idx_r == 5'd12) byte_v = "I";
        else if (idx_r == 5'd13) byte_v = "E";
        else if (idx_r == 5'd14) byte_v = "N";
        else if (idx_r == 5'd15) byte_v = "D";
        else byte_v = pse_pkg::be_byte(pse_pkg::IEND_CRC, idx_r[1:0]);
        true_last    = (idx_r == 5'd19);
        sum.crc_feed = adv && (idx_r < 5'd4);
        if (adv) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 5'd19) begin
            open_nxt       = 1'b0;
            col_nxt        = '0;
            row_nxt        = '0;
            blk_nxt        = '0;
            stream_nxt     = '0;
            sum.crc_init   = 1'b1;
            sum.adler_init = 1'b1;
            sum.crc_feed   = 1'b0;
            state_nxt      = pse_pkg::ST_IDLE;
          end
        end
      end
      pse_pkg::ST_ERR: begin
        emit      = 1'b1;
        err_byte  = 1'b1;
        true_last = 1'b1;
        if (adv) begin
          open_nxt       = 1'b0;
          col_nxt        = '0;
          row_nxt        = '0;
          blk_nxt        = '0;
          stream_nxt     = '0;
          sum.crc_init   = 1'b1;
          sum.adler_init = 1'b1;
          state_nxt      = pse_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pse_pkg::ST_IDLE;
    endcase
    sum.data = byte_v;
    if (adv && state_r != pse_pkg::ST_IDLE) cnt_nxt = visible ? cnt_r + 1'b1 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pse_pkg::ST_IDLE;
      open_r   <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      blk_r    <= '0;
      stream_r <= '0;
      idx_r    <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      open_r   <= open_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      blk_r    <= blk_nxt;
      stream_r <= stream_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
    end
    n_r    <= n_nxt;
    s_r    <= s_nxt;
    prod_r <= prod_nxt;
    len_r  <= len_nxt;
    px_r   <= px_nxt;
  end

  // output register: load a word when empty or taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv && visible) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
    if (adv && visible) begin
      ob_r <= byte_v;
      ol_r <= true_last || (cnt_r == pse_pkg::OUT_CAP - 1'b1);
      of_r <= err_byte;
    end
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.out_byte = ob_r;
  assign out_ch.run_last = ol_r;
  assign out_ch.failed   = of_r;
endmodule

### hw/rtl/pse_checker.sv
// Port-level assertions of the PNG encoder and their bind
`timescale 1ns / 1ps
`include "png_stored_image_encoder_defines.svh"
module pse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       failed
);
  // an error word stands alone as the last word of its run
  `PSE_ASSERT_IMP(a_fail_last, out_valid && failed, run_last, "error word without run_last")
  `PSE_ASSERT_IMP(a_fail_zero, out_valid && failed, out_byte == 8'd0, "error word not zero")
  // one input word at a time
  `PSE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "ready after accept")
  // a stalled word holds
  `PSE_ASSERT_NEXT(a_hold, out_valid && !out_ready,
                   out_valid && $stable(out_byte) && $stable(run_last), "stalled word moved")
endmodule

bind png_stored_image_encoder pse_checker u_pse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .run_last  (out_ch.run_last),
  .failed    (out_ch.failed)
);
